>>> hdl/tbi_pkg.sv
// Shared types and constants for the bilinear table interpolation block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package tbi_pkg;

  typedef enum logic [1:0] {
    CMD_LOOKUP  = 2'd0,
    CMD_WR_X    = 2'd1,
    CMD_WR_Y    = 2'd2,
    CMD_WR_CELL = 2'd3
  } cmd_t;

  // Register select taken from the word address of the configuration port.
  localparam logic REG_X_POINTS = 1'b0;
  localparam logic REG_Y_POINTS = 1'b1;

  localparam logic [4:0] POINTS_RESET = 5'd16;

  // Weight of one in unsigned Q0.16, held in 17 bits.
  localparam logic [16:0] WEIGHT_ONE = 17'h10000;

  // One beat as it sits in the queue between the two halves.
  typedef struct packed {
    cmd_t               cmd;
    logic               lookup;
    logic               wr_ok;
    logic [3:0]         x_slot;
    logic [3:0]         y_slot;
    logic signed [31:0] write_value;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
  } item_t;

endpackage

`default_nettype wire

>>> hdl/table_interpolate_2d_bilinear_core.sv
// Top level of the bilinear table interpolation block: configuration registers
// and the two halves. Depends on tbi_pkg, tbi_front and tbi_back.
`default_nettype none

// A beat is accepted on a rising edge with start high and busy low. Write beats
// (X breakpoint, Y breakpoint, grid cell) store one entry and give a result of
// all zeros in the cycle after they leave the queue. A lookup beat searches each
// axis in turn and then blends the four surrounding grid cells. An axis input at
// or above its last breakpoint, or at or below its first, clamps to that end;
// otherwise up to points-1 segments are scanned, one breakpoint read a cycle
// from the axis store, and the weight in the segment found is taken from the
// shared divider, one quotient bit a cycle. A two-beat queue lets further beats
// be accepted while a lookup runs; busy rises only when the queue is full. Each
// result is shown for a single cycle with result_valid high and must be captured
// then, as the block cannot be stalled. Every store entry must be written before
// a lookup reads it. The point counts are written over the APB port (x_points at
// byte 0, y_points at byte 4); the user must write them only while the block is
// idle, as the block itself does not enforce this.
module table_interpolate_2d_bilinear_core #(
  parameter int MAX_X_POINTS = 16,
  parameter int MAX_Y_POINTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               start,
  output logic                    busy,
  input  wire tbi_pkg::cmd_t      cmd,
  input  wire logic [3:0]         x_slot,
  input  wire logic [3:0]         y_slot,
  input  wire logic signed [31:0] write_value,
  input  wire logic signed [31:0] x_in,
  input  wire logic signed [31:0] y_in,
  output logic                    result_valid,
  output logic signed [31:0]      interp_value,
  output logic [3:0]              x_segment,
  output logic [3:0]              y_segment,
  output logic                    saturated
);

  logic [4:0]     x_points;
  logic [4:0]     y_points;
  logic           head_valid;
  tbi_pkg::item_t head;
  logic           pop;
  logic           cfg_wr;

  // The port never inserts wait states; only the word bit of the address is decoded.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_points <= tbi_pkg::POINTS_RESET;
      y_points <= tbi_pkg::POINTS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        tbi_pkg::REG_X_POINTS: x_points <= pwdata[4:0];
        tbi_pkg::REG_Y_POINTS: y_points <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      tbi_pkg::REG_X_POINTS: prdata = {27'd0, x_points};
      tbi_pkg::REG_Y_POINTS: prdata = {27'd0, y_points};
      default:               prdata = '0;
    endcase
  end

  // The front half queues beats; the back half owns the stores and does the arithmetic.
  tbi_front #(
    .MAX_X_POINTS(MAX_X_POINTS),
    .MAX_Y_POINTS(MAX_Y_POINTS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .x_slot      (x_slot),
    .y_slot      (y_slot),
    .write_value (write_value),
    .x_in        (x_in),
    .y_in        (y_in),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop)
  );

  tbi_back #(
    .MAX_X_POINTS(MAX_X_POINTS),
    .MAX_Y_POINTS(MAX_Y_POINTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .x_points     (x_points),
    .y_points     (y_points),
    .result_valid (result_valid),
    .interp_value (interp_value),
    .x_segment    (x_segment),
    .y_segment    (y_segment),
    .saturated    (saturated)
  );

endmodule

`default_nettype wire

>>> hdl/tbi_front.sv
// Front half: accepts command beats, classifies them and queues them.
// Depends on tbi_pkg for the queued item type.
`default_nettype none

module tbi_front #(
  parameter int MAX_X_POINTS = 16,
  parameter int MAX_Y_POINTS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire tbi_pkg::cmd_t       cmd,
  input  wire logic [3:0]          x_slot,
  input  wire logic [3:0]          y_slot,
  input  wire logic signed [31:0]  write_value,
  input  wire logic signed [31:0]  x_in,
  input  wire logic signed [31:0]  y_in,
  output logic                     head_valid,
  output tbi_pkg::item_t           head,
  input  wire logic                pop
);

  tbi_pkg::item_t q [2];
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;
  logic           push;
  tbi_pkg::item_t incoming;
  logic           x_ok;
  logic           y_ok;

  assign busy       = (cnt == 2'd2);
  assign push       = start && !busy;
  assign head_valid = (cnt != 2'd0);
  assign head       = q[rp];

  assign x_ok = (int'(x_slot) < MAX_X_POINTS);
  assign y_ok = (int'(y_slot) < MAX_Y_POINTS);

  // Writes aimed beyond a store are flagged here so the back half simply skips them.
  always_comb begin
    incoming.cmd         = cmd;
    incoming.lookup      = (cmd == tbi_pkg::CMD_LOOKUP);
    incoming.x_slot      = x_slot;
    incoming.y_slot      = y_slot;
    incoming.write_value = write_value;
    incoming.x_in        = x_in;
    incoming.y_in        = y_in;
    unique case (cmd)
      tbi_pkg::CMD_WR_X:    incoming.wr_ok = x_ok;
      tbi_pkg::CMD_WR_Y:    incoming.wr_ok = y_ok;
      tbi_pkg::CMD_WR_CELL: incoming.wr_ok = x_ok && y_ok;
      default:              incoming.wr_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      priority if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end else begin
        cnt <= cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= incoming;
    end
  end

`ifndef SYNTH
  a_cnt_bound : assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue fill count out of range");
  a_no_underflow : assert property (@(posedge clk) disable iff (rst) pop |-> cnt != 2'd0)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

>>> hdl/tbi_back.sv
// Back half: breakpoint and grid stores, axis search, weight division and blend.
// Depends on tbi_pkg for the queued item type and command codes.
`default_nettype none

module tbi_back #(
  parameter int MAX_X_POINTS = 16,
  parameter int MAX_Y_POINTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               head_valid,
  input  wire tbi_pkg::item_t     head,
  output logic                    pop,
  input  wire logic [4:0]         x_points,
  input  wire logic [4:0]         y_points,
  output logic                    result_valid,
  output logic signed [31:0]      interp_value,
  output logic [3:0]              x_segment,
  output logic [3:0]              y_segment,
  output logic                    saturated
);

  localparam int XAW  = $clog2(MAX_X_POINTS);
  localparam int YAW  = $clog2(MAX_Y_POINTS);
  localparam int SW   = (XAW > YAW) ? XAW : YAW;
  localparam int MAXP = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
  localparam int NW   = $clog2(MAXP + 1);
  localparam int GD   = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int GAW  = $clog2(GD);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_AX_START  = 7'b0000010,
    ST_CHK_LAST  = 7'b0000100,
    ST_CHK_FIRST = 7'b0001000,
    ST_SCAN      = 7'b0010000,
    ST_DIV       = 7'b0100000,
    ST_BLEND     = 7'b1000000
  } state_t;

  logic signed [31:0] x_mem    [MAX_X_POINTS];
  logic signed [31:0] y_mem    [MAX_Y_POINTS];
  logic signed [31:0] cell_mem [GD];

  state_t             state;
  state_t             state_next;
  logic               axis;
  tbi_pkg::item_t     cur;
  logic [SW-1:0]      k;
  logic [3:0]         dcnt;
  logic [2:0]         step;
  logic signed [32:0] lo;
  logic [32:0]        rem;
  logic [32:0]        span;
  logic [15:0]        quo;
  logic [SW-1:0]      sx;
  logic [SW-1:0]      sy;
  logic [16:0]        wx;
  logic [16:0]        wy;
  logic signed [31:0] xq;
  logic signed [31:0] yq;
  logic signed [31:0] cell_q;
  logic signed [67:0] prod;
  logic signed [67:0] acc;
  logic signed [49:0] a0;
  logic signed [49:0] a1;

  logic [NW-1:0]      nx;
  logic [NW-1:0]      ny;
  logic [NW-1:0]      n_cur;
  logic signed [32:0] in_cur;
  logic signed [32:0] bp;
  logic [SW-1:0]      ra;
  logic [GAW-1:0]     ca;
  logic [GAW-1:0]     wa;
  logic               fin;
  logic [SW-1:0]      fin_seg;
  logic [16:0]        fin_w;
  logic               div_go;
  logic [33:0]        rem2;
  logic               rem_ge;
  logic [32:0]        rem_n;
  logic               scan_last;
  logic signed [49:0] ma;
  logic signed [17:0] mb;
  logic [16:0]        wx1;
  logic [16:0]        wy1;
  logic signed [67:0] total;
  logic               ovf;

  // Point counts below two act as two, above the store depth as the depth.
  always_comb begin
    priority if (x_points < 5'd2) begin
      nx = NW'(2);
    end else if (int'(x_points) > MAX_X_POINTS) begin
      nx = NW'(MAX_X_POINTS);
    end else begin
      nx = NW'(x_points);
    end
    priority if (y_points < 5'd2) begin
      ny = NW'(2);
    end else if (int'(y_points) > MAX_Y_POINTS) begin
      ny = NW'(MAX_Y_POINTS);
    end else begin
      ny = NW'(y_points);
    end
  end

  assign n_cur     = axis ? ny : nx;
  assign in_cur    = axis ? 33'(cur.y_in) : 33'(cur.x_in);
  assign bp        = axis ? 33'(yq) : 33'(xq);
  assign scan_last = (NW'(k) == n_cur - NW'(2));
  assign wx1       = tbi_pkg::WEIGHT_ONE - wx;
  assign wy1       = tbi_pkg::WEIGHT_ONE - wy;

  assign rem2   = {rem, 1'b0};
  assign rem_ge = (rem2 >= {1'b0, span});
  assign rem_n  = rem_ge ? 33'(rem2 - {1'b0, span}) : rem2[32:0];

  always_comb begin
    unique case (state)
      ST_AX_START:  ra = SW'(n_cur - NW'(1));
      ST_CHK_LAST:  ra = '0;
      ST_CHK_FIRST: ra = SW'(1);
      ST_SCAN:      ra = SW'(NW'(k) + NW'(2));
      default:      ra = '0;
    endcase
  end

  always_comb begin
    unique case (step)
      3'd0:    ca = GAW'(int'(sx) * MAX_Y_POINTS + int'(sy));
      3'd1:    ca = GAW'(int'(sx) * MAX_Y_POINTS + int'(sy) + 1);
      3'd2:    ca = GAW'((int'(sx) + 1) * MAX_Y_POINTS + int'(sy));
      3'd3:    ca = GAW'((int'(sx) + 1) * MAX_Y_POINTS + int'(sy) + 1);
      default: ca = '0;
    endcase
  end

  assign wa = GAW'(int'(head.x_slot) * MAX_Y_POINTS + int'(head.y_slot));

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    fin        = 1'b0;
    fin_seg    = '0;
    fin_w      = '0;
    div_go     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          if (head.lookup) begin
            state_next = ST_AX_START;
          end
        end
      end
      ST_AX_START: begin
        state_next = ST_CHK_LAST;
      end
      ST_CHK_LAST: begin
        if (in_cur >= bp) begin
          fin     = 1'b1;
          fin_seg = SW'(n_cur - NW'(2));
          fin_w   = tbi_pkg::WEIGHT_ONE;
        end else begin
          state_next = ST_CHK_FIRST;
        end
      end
      ST_CHK_FIRST: begin
        if (in_cur <= bp) begin
          fin = 1'b1;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (in_cur >= lo && in_cur < bp) begin
          div_go     = 1'b1;
          state_next = ST_DIV;
        end else if (scan_last) begin
          fin = 1'b1;
        end
      end
      ST_DIV: begin
        if (dcnt == 4'd15) begin
          fin     = 1'b1;
          fin_seg = k;
          fin_w   = {1'b0, quo[14:0], rem_ge};
        end
      end
      ST_BLEND: begin
        if (step == 3'd7) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (fin) begin
      state_next = axis ? ST_BLEND : ST_AX_START;
    end
  end

  always_comb begin
    unique case (step)
      3'd1, 3'd3: begin
        ma = 50'(cell_q);
        mb = {1'b0, wy1};
      end
      3'd2, 3'd4: begin
        ma = 50'(cell_q);
        mb = {1'b0, wy};
      end
      3'd5: begin
        ma = a0;
        mb = {1'b0, wx1};
      end
      3'd6: begin
        ma = a1;
        mb = {1'b0, wx};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign total = acc + prod;
  assign ovf   = !((total[67:63] == 5'b00000) || (total[67:63] == 5'b11111));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      axis         <= 1'b0;
      step         <= 3'd0;
      dcnt         <= 4'd0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (pop) begin
        axis <= 1'b0;
        if (!head.lookup) begin
          result_valid <= 1'b1;
        end
      end
      if (div_go) begin
        dcnt <= 4'd0;
      end else if (state == ST_DIV) begin
        dcnt <= dcnt + 4'd1;
      end
      if (fin) begin
        axis <= 1'b1;
        step <= 3'd0;
      end else if (state == ST_BLEND) begin
        step <= step + 3'd1;
        if (step == 3'd7) begin
          result_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    xq     <= x_mem[XAW'(ra)];
    yq     <= y_mem[YAW'(ra)];
    cell_q <= cell_mem[ca];
    prod   <= ma * mb;
    if (pop) begin
      cur <= head;
      if (head.wr_ok) begin
        unique case (head.cmd)
          tbi_pkg::CMD_WR_X:    x_mem[XAW'(head.x_slot)] <= head.write_value;
          tbi_pkg::CMD_WR_Y:    y_mem[YAW'(head.y_slot)] <= head.write_value;
          tbi_pkg::CMD_WR_CELL: cell_mem[wa]             <= head.write_value;
          default: begin
          end
        endcase
      end
      interp_value <= '0;
      x_segment    <= '0;
      y_segment    <= '0;
      saturated    <= 1'b0;
    end
    if (state == ST_CHK_FIRST) begin
      lo <= bp;
      k  <= '0;
    end else if (state == ST_SCAN && !div_go) begin
      lo <= bp;
      k  <= k + SW'(1);
    end
    if (div_go) begin
      rem  <= 33'(in_cur - lo);
      span <= 33'(bp - lo);
      quo  <= '0;
    end else if (state == ST_DIV) begin
      rem <= rem_n;
      quo <= {quo[14:0], rem_ge};
    end
    if (fin) begin
      if (axis) begin
        sy <= fin_seg;
        wy <= fin_w;
      end else begin
        sx <= fin_seg;
        wx <= fin_w;
      end
    end
    if (state == ST_BLEND) begin
      unique case (step)
        3'd2, 3'd4, 3'd6: acc <= prod;
        3'd3:             a0  <= 50'(total);
        3'd5:             a1  <= 50'(total);
        3'd7: begin
          interp_value <= ovf ? (total[67] ? 32'sh80000000 : 32'sh7fffffff)
                              : total[63:32];
          saturated    <= ovf;
          x_segment    <= 4'(sx);
          y_segment    <= 4'(sy);
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  a_pop_idle : assert property (@(posedge clk) disable iff (rst)
    pop |-> state == ST_IDLE)
    else $error("item taken from queue while busy");
  a_rem_below_span : assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < span)
    else $error("division remainder not below span");
`endif

endmodule

`default_nettype wire

>>> dv/table_interpolate_2d_bilinear_core_tb.sv
// Self-checking testbench for table_interpolate_2d_bilinear_core.
// Depends on tbi_pkg and the RTL of the block; the scoreboard class lives in this file.
`default_nettype none

module table_interpolate_2d_bilinear_core_tb;

  // Expected content of one result beat.
  typedef struct {
    logic signed [31:0] value;
    logic [3:0]         xseg;
    logic [3:0]         yseg;
    logic               sat;
  } blend_result_t;

  // The scoreboard keeps its own copy of the axes, the grid and the point
  // counts. Each accepted command beat is turned into the result it must give.
  class blend_scoreboard;
    longint        xbp[16];
    longint        ybp[16];
    longint        cells[256];
    logic [4:0]    x_count;
    logic [4:0]    y_count;
    blend_result_t pending[$];
    int            errors;
    int            results_seen;
    int            lookups;
    int            clamped_lo;
    int            clamped_hi;

    function new();
      x_count = tbi_pkg::POINTS_RESET;
      y_count = tbi_pkg::POINTS_RESET;
    endfunction

    function int points_used(logic [4:0] reg_val);
      if (reg_val < 2) return 2;
      if (reg_val > 16) return 16;
      return reg_val;
    endfunction

    // Segment and Q0.16 weight on one axis; weight one is 65536.
    function void locate(bit on_x, longint v, output int seg, output longint w);
      int n;
      longint p[16];
      longint span;
      if (on_x) begin
        n = points_used(x_count);
        p = xbp;
      end else begin
        n = points_used(y_count);
        p = ybp;
      end
      seg = 0;
      w = 0;
      if (v >= p[n-1]) begin
        seg = n - 2;
        w = 65536;
        clamped_hi++;
        return;
      end
      if (v <= p[0]) begin
        clamped_lo++;
        return;
      end
      for (int k = 0; k + 1 < n; k++) begin
        if (v >= p[k] && v < p[k+1]) begin
          span = p[k+1] - p[k];
          seg = k;
          if (span > 0) w = ((v - p[k]) << 16) / span;
          return;
        end
      end
    endfunction

    function void note_beat(tbi_pkg::cmd_t c, logic [3:0] xs, logic [3:0] ys,
                            logic signed [31:0] wv, logic signed [31:0] xi,
                            logic signed [31:0] yi);
      blend_result_t r;
      int sx, sy;
      longint wx, wy;
      logic [63:0] total, f00, f01, f10, f11, wx1, wy1;
      r = '{value: '0, xseg: '0, yseg: '0, sat: 1'b0};
      case (c)
        tbi_pkg::CMD_WR_X:    xbp[xs] = longint'(wv);
        tbi_pkg::CMD_WR_Y:    ybp[ys] = longint'(wv);
        tbi_pkg::CMD_WR_CELL: cells[xs*16 + ys] = longint'(wv);
        default: begin
          lookups++;
          locate(1'b1, longint'(xi), sx, wx);
          locate(1'b0, longint'(yi), sy, wy);
          wx1 = 65536 - wx;
          wy1 = 65536 - wy;
          f00 = cells[sx*16 + sy];
          f01 = cells[sx*16 + sy + 1];
          f10 = cells[(sx+1)*16 + sy];
          f11 = cells[(sx+1)*16 + sy + 1];
          // Modular 64-bit sum in Q32.32; the high word is the floored blend.
          total = f00 * (wx1 * wy1) + f10 * (64'(wx) * wy1)
                + f01 * (wx1 * 64'(wy)) + f11 * (64'(wx) * 64'(wy));
          r.value = total[63:32];
          r.xseg = sx[3:0];
          r.yseg = sy[3:0];
        end
      endcase
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic signed [31:0] v, logic [3:0] xs, logic [3:0] ys,
                      logic s);
      blend_result_t e;
      results_seen++;
      if (pending.size() == 0) begin
        report("result beat with nothing outstanding");
        return;
      end
      e = pending.pop_front();
      if (v !== e.value)
        report($sformatf("interp_value %h, expected %h", v, e.value));
      if (xs !== e.xseg)
        report($sformatf("x_segment %0d, expected %0d", xs, e.xseg));
      if (ys !== e.yseg)
        report($sformatf("y_segment %0d, expected %0d", ys, e.yseg));
      if (s !== e.sat)
        report($sformatf("saturated %b, expected %b", s, e.sat));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               busy;
  tbi_pkg::cmd_t      cmd = tbi_pkg::CMD_LOOKUP;
  logic [3:0]         x_slot = '0;
  logic [3:0]         y_slot = '0;
  logic signed [31:0] write_value = '0;
  logic signed [31:0] x_in = '0;
  logic signed [31:0] y_in = '0;
  logic               result_valid;
  logic signed [31:0] interp_value;
  logic [3:0]         x_segment;
  logic [3:0]         y_segment;
  logic               saturated;

  blend_scoreboard sb = new();
  bit              idle_free;  // set for stretches where the sender never pauses

  table_interpolate_2d_bilinear_core dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .cmd, .x_slot, .y_slot, .write_value, .x_in, .y_in,
    .result_valid, .interp_value, .x_segment, .y_segment, .saturated
  );

  initial forever #2 clk = ~clk;

  // Limit: far beyond the slowest legal run of about 1900 beats plus the
  // sender's longest gaps.
  initial begin
    #8000000;
    $display("table_interpolate_2d_bilinear_core_tb: done, errors");
    $finish;
  end

  // The result beat is present for one cycle only, so it is taken at the edge
  // that closes that cycle, reading the values the block held before it.
  always @(posedge clk) begin
    if (!rst && result_valid)
      sb.check_result(interp_value, x_segment, y_segment, saturated);
  end

  // Mostly short pauses, a few long ones, none at all in idle-free stretches.
  function int pick_gap();
    int r;
    if (idle_free) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  // Drives one command beat and holds it until the block takes it. start is
  // left high when the next beat follows straight on, so that it is never
  // dropped and raised again within one time step.
  task send_beat(tbi_pkg::cmd_t c, logic [3:0] xs, logic [3:0] ys,
                 logic signed [31:0] wv, logic signed [31:0] xi,
                 logic signed [31:0] yi);
    int gap;
    start <= 1'b1;
    cmd <= c;
    x_slot <= xs;
    y_slot <= ys;
    write_value <= wv;
    x_in <= xi;
    y_in <= yi;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_beat(c, xs, ys, wv, xi, yi);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds off new beats until every outstanding result has come back.
  task drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Point counts are only changed with the block idle. The two writes follow
  // each other directly, the second setup phase straight after the first access.
  task set_points(logic [4:0] nx, logic [4:0] ny);
    drain();
    for (int i = 0; i < 2; i++) begin
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= (i == 0) ? 3'(tbi_pkg::REG_X_POINTS) << 2
                        : 3'(tbi_pkg::REG_Y_POINTS) << 2;
      pwdata <= {27'(32'($urandom)), (i == 0) ? nx : ny};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    sb.x_count = nx;
    sb.y_count = ny;
    @(posedge clk);
  endtask

  // Loads one whole axis. Sorted axes use random steps, some of them zero so
  // that equal neighbours appear; an unsorted axis takes raw random values.
  task load_axis(bit on_x, bit sorted);
    longint level;
    logic signed [31:0] v;
    level = longint'($signed(32'($urandom))) >>> $urandom_range(4, 12);
    for (int k = 0; k < 16; k++) begin
      if (sorted) begin
        v = 32'(level);
        if ($urandom_range(0, 9) != 0) level += $urandom_range(1, 1 << $urandom_range(4, 20));
      end else begin
        v = $urandom;
      end
      if (on_x)
        send_beat(tbi_pkg::CMD_WR_X, 4'(k), 4'($urandom), v, $urandom, $urandom);
      else
        send_beat(tbi_pkg::CMD_WR_Y, 4'($urandom), 4'(k), v, $urandom, $urandom);
    end
  endtask

  function logic signed [31:0] pick_cell_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  // Lookup inputs aimed at the segments in use, with some beyond the ends,
  // some exactly on a breakpoint and some fully random.
  function logic signed [31:0] pick_input(bit on_x);
    int n, k, r;
    longint lo, hi;
    n = on_x ? sb.points_used(sb.x_count) : sb.points_used(sb.y_count);
    k = $urandom_range(0, n - 2);
    lo = on_x ? sb.xbp[k] : sb.ybp[k];
    hi = on_x ? sb.xbp[k+1] : sb.ybp[k+1];
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom;
    if (r < 14) return 32'((on_x ? sb.xbp[0] : sb.ybp[0]) - $urandom_range(0, 5000));
    if (r < 20) return 32'((on_x ? sb.xbp[n-1] : sb.ybp[n-1]) + $urandom_range(0, 5000));
    if (r < 30) return 32'(lo);
    if (hi > lo) return 32'(lo + longint'($urandom) % (hi - lo));
    return 32'(lo);
  endfunction

  task random_phase(int beats);
    int r;
    for (int i = 0; i < beats; i++) begin
      if (i % 100 == 0) idle_free = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 75)
        send_beat(tbi_pkg::CMD_LOOKUP, 4'($urandom), 4'($urandom), $urandom,
                  pick_input(1'b1), pick_input(1'b0));
      else if (r < 93)
        send_beat(tbi_pkg::CMD_WR_CELL, 4'($urandom), 4'($urandom), pick_cell_value(),
                  $urandom, $urandom);
      else
        // A stray breakpoint write: may leave the axis unsorted.
        send_beat((r < 96) ? tbi_pkg::CMD_WR_X : tbi_pkg::CMD_WR_Y,
                  4'($urandom), 4'($urandom), $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every store is written before the first lookup, so no lookup can ever
    // read an entry that was never written.
    load_axis(1'b1, 1'b1);
    load_axis(1'b0, 1'b1);
    for (int c = 0; c < 256; c++)
      send_beat(tbi_pkg::CMD_WR_CELL, 4'(c / 16), 4'(c % 16), pick_cell_value(),
                $urandom, $urandom);

    // Directed beats: full-scale and end-point inputs, values on the last
    // cell, and inputs sitting on or between breakpoints.
    send_beat(tbi_pkg::CMD_LOOKUP, 4'hf, 4'hf, 32'sh7fffffff, 32'sh7fffffff,
              32'sh80000000);
    send_beat(tbi_pkg::CMD_LOOKUP, 4'h0, 4'h0, 32'sh80000000, 32'sh80000000,
              32'sh7fffffff);
    send_beat(tbi_pkg::CMD_LOOKUP, 4'h0, 4'h0, 0, 32'(sb.xbp[0]), 32'(sb.ybp[0]));
    send_beat(tbi_pkg::CMD_LOOKUP, 4'h0, 4'h0, 0, 32'(sb.xbp[15]), 32'(sb.ybp[15]));
    send_beat(tbi_pkg::CMD_LOOKUP, 4'h0, 4'h0, 0, 32'(sb.xbp[7]), 32'(sb.ybp[8]));
    send_beat(tbi_pkg::CMD_LOOKUP, 4'h5, 4'ha, 0, pick_input(1'b1), pick_input(1'b0));
    send_beat(tbi_pkg::CMD_WR_CELL, 4'hf, 4'hf, 32'sh7fffffff, 0, 0);
    send_beat(tbi_pkg::CMD_WR_CELL, 4'hf, 4'he, 32'sh80000000, 0, 0);
    send_beat(tbi_pkg::CMD_WR_CELL, 4'he, 4'hf, 32'sh7fffffff, 0, 0);
    send_beat(tbi_pkg::CMD_WR_CELL, 4'he, 4'he, 32'sh80000000, 0, 0);
    send_beat(tbi_pkg::CMD_LOOKUP, 4'h0, 4'h0, 0, 32'sh7fffffff, 32'sh7fffffff);
    send_beat(tbi_pkg::CMD_LOOKUP, 4'h0, 4'h0, 0,
              32'(sb.xbp[14] + (sb.xbp[15] - sb.xbp[14]) / 2),
              32'(sb.ybp[14] + (sb.ybp[15] - sb.ybp[14]) / 3));

    // Random part over several point-count settings, the extremes included.
    // Most settings reload one axis; one of them gets an unsorted axis.
    random_phase(300);
    set_points(5'd2, 5'd2);
    random_phase(200);
    set_points(5'd0, 5'd1);
    load_axis(1'b1, 1'b1);
    random_phase(200);
    set_points(5'd31, 5'd17);
    load_axis(1'b0, 1'b0);
    random_phase(250);
    set_points(5'd5, 5'd9);
    load_axis(1'b0, 1'b1);
    random_phase(120);
    drain();
    random_phase(150);
    set_points(5'd16, 5'd3);
    load_axis(1'b1, 1'b1);
    random_phase(250);

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d lookups (%0d clamped low, %0d clamped high on an axis) and",
             sb.lookups, sb.clamped_lo, sb.clamped_hi);
    $display("%0d result beats over six point-count settings; %0d mismatches.",
             sb.results_seen, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("table_interpolate_2d_bilinear_core_tb: done, clean");
    else
      $display("table_interpolate_2d_bilinear_core_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hdl/tbi_pkg.sv
hdl/tbi_front.sv
hdl/tbi_back.sv
hdl/table_interpolate_2d_bilinear_core.sv
dv/table_interpolate_2d_bilinear_core_tb.sv
